// ----- hw/rtl/mcs_pkg.sv -----
package mcs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NUM_LANES = 3;
    localparam int OUT_BITS = 8;
    localparam int DIV_STEPS = OUT_BITS;
    localparam int CNT_BITS = $clog2(DIV_STEPS);
    localparam int PIXEL_BITS = NUM_LANES * OUT_BITS;
    localparam logic [OUT_BITS-1:0] PIX_MAX = {OUT_BITS{1'b1}};

    localparam int LANE_RED = 2;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE = 0;

    typedef struct packed {
        logic load_stats;
        logic restart;
        logic load_div;
        logic step;
    } lane_ctrl_t;

endpackage

// ----- hw/rtl/mcs_lane.sv -----
module mcs_lane #(
    parameter int SAMPLE_BITS = mcs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mcs_pkg::lane_ctrl_t            ctrl,
    input  logic [SAMPLE_BITS-1:0]         sample,
    output logic [mcs_pkg::OUT_BITS-1:0]   value
);

    localparam int OB = mcs_pkg::OUT_BITS;

    logic [SAMPLE_BITS-1:0]    min_reg, min_next;
    logic [SAMPLE_BITS-1:0]    max_reg, max_next;
    logic [SAMPLE_BITS-1:0]    range_reg;
    logic [SAMPLE_BITS-1:0]    rem_reg, rem_next;
    logic [OB-1:0]             nlo_reg, nlo_next;
    logic [OB-1:0]             quo_reg, quo_next;
    logic                      zero_reg;
    logic                      sat_reg;

    logic [SAMPLE_BITS-1:0]    delta;
    logic [SAMPLE_BITS-1:0]    range;
    logic [SAMPLE_BITS+OB-1:0] prod;
    logic                      zero_case;
    logic                      sat_case;
    logic [SAMPLE_BITS:0]      rem_sh;
    logic [SAMPLE_BITS:0]      diff;
    logic                      fits;

    always_comb begin
        delta     = sample - min_reg;
        range     = max_reg - min_reg;
        prod      = {delta, {OB{1'b0}}} - {{OB{1'b0}}, delta};
        zero_case = (max_reg <= min_reg) || (sample <= min_reg);
        sat_case  = (delta >= range);
    end

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.load_stats) begin
            if (ctrl.restart) begin
                min_next = sample;
                max_next = sample;
            end else begin
                if (sample < min_reg) begin
                    min_next = sample;
                end
                if (sample > max_reg) begin
                    max_next = sample;
                end
            end
        end
    end

    always_comb begin
        rem_sh   = {rem_reg, nlo_reg[OB-1]};
        diff     = rem_sh - {1'b0, range_reg};
        fits     = !diff[SAMPLE_BITS];
        rem_next = fits ? diff[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
        nlo_next = {nlo_reg[OB-2:0], 1'b0};
        quo_next = {quo_reg[OB-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= {SAMPLE_BITS{1'b1}};
            max_reg <= '0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_div) begin
            range_reg <= range;
            rem_reg   <= prod[SAMPLE_BITS+OB-1:OB];
            nlo_reg   <= prod[OB-1:0];
            quo_reg   <= '0;
            zero_reg  <= zero_case;
            sat_reg   <= sat_case;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            nlo_reg <= nlo_next;
            quo_reg <= quo_next;
        end
    end

    assign value = zero_reg ? '0 : (sat_reg ? mcs_pkg::PIX_MAX : quo_reg);

endmodule

// ----- hw/rtl/mcs_merge.sv -----
module mcs_merge (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             load,
    input  logic                                             stretch,
    input  logic [mcs_pkg::NUM_LANES-1:0][mcs_pkg::OUT_BITS-1:0] lane_value,
    input  logic                                             m_ready,
    output logic                                             m_valid,
    output logic                                             out_free,
    output logic                                             pixel_valid,
    output logic [mcs_pkg::PIXEL_BITS-1:0]                   pixel_out
);

    logic                           valid_reg;
    logic                           pvalid_reg;
    logic [mcs_pkg::PIXEL_BITS-1:0] pixel_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pvalid_reg <= stretch;
            pixel_reg  <= stretch ? lane_value : '0;
        end
    end

    assign m_valid     = valid_reg;
    assign pixel_valid = pvalid_reg;
    assign pixel_out   = pixel_reg;

endmodule

// ----- hw/rtl/minmax_contrast_stretch.sv -----
// Channel   Ports                                        Direction
// input     s_valid s_ready s_action s_first s_*_in      sink
// result    m_valid m_ready m_pixel_valid m_pixel_out    source
//
// A statistics beat updates the three lane min/max registers at acceptance and
// its result enters the output register in the same edge when that register is free.
// A stretch beat runs the three lane dividers in parallel for eight quotient steps,
// and its result enters the output register from the wait state once that register is free.
// Reset sets every minimum to all ones and every maximum to zero.
// A stalled result holds in the output register; a new beat is accepted in the meantime.
module minmax_contrast_stretch #(
    parameter int SAMPLE_BITS = mcs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_action,
    input  logic                             s_first,
    input  logic [SAMPLE_BITS-1:0]           s_red_in,
    input  logic [SAMPLE_BITS-1:0]           s_green_in,
    input  logic [SAMPLE_BITS-1:0]           s_blue_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_pixel_valid,
    output logic [mcs_pkg::PIXEL_BITS-1:0]   m_pixel_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [mcs_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;

    logic                           accept;
    logic                           out_free;
    logic                           out_load;
    logic                           out_stretch;
    mcs_pkg::lane_ctrl_t            ctrl;
    logic [SAMPLE_BITS-1:0]         lane_sample [mcs_pkg::NUM_LANES];
    logic [mcs_pkg::NUM_LANES-1:0][mcs_pkg::OUT_BITS-1:0] lane_value;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        ctrl.load_stats = accept && !s_action;
        ctrl.restart    = s_first;
        ctrl.load_div   = accept && s_action;
        ctrl.step       = (state_reg == ST_DIV);
    end

    always_comb begin
        lane_sample[mcs_pkg::LANE_RED]   = s_red_in;
        lane_sample[mcs_pkg::LANE_GREEN] = s_green_in;
        lane_sample[mcs_pkg::LANE_BLUE]  = s_blue_in;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        out_load    = 1'b0;
        out_stretch = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action) begin
                        state_next = ST_DIV;
                        cnt_next   = '0;
                    end else if (out_free) begin
                        out_load = 1'b1;
                    end else begin
                        state_next = ST_WAIT;
                        pend_next  = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mcs_pkg::CNT_BITS'(mcs_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_WAIT;
                    pend_next  = 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_stretch = pend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    for (genvar g = 0; g < mcs_pkg::NUM_LANES; g++) begin : g_lane
        mcs_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .sample  (lane_sample[g]),
            .value   (lane_value[g])
        );
    end

    mcs_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .stretch     (out_stretch),
        .lane_value  (lane_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .out_free    (out_free),
        .pixel_valid (m_pixel_valid),
        .pixel_out   (m_pixel_out)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int SAMPLE_BITS = mcs_pkg::SAMPLE_BITS_DEF;
    localparam int NUM_LANES = mcs_pkg::NUM_LANES;
    localparam int OUT_BITS = mcs_pkg::OUT_BITS;
    localparam int PIXEL_BITS = mcs_pkg::PIXEL_BITS;
    localparam logic [OUT_BITS-1:0] PIX_MAX = mcs_pkg::PIX_MAX;
    localparam int LANE_RED = mcs_pkg::LANE_RED;
    localparam int LANE_GREEN = mcs_pkg::LANE_GREEN;
    localparam int LANE_BLUE = mcs_pkg::LANE_BLUE;
    localparam logic ACT_STATS = 1'b0;
    localparam logic ACT_STRETCH = 1'b1;
    localparam int TARGET_BEATS = 1700;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic                  pixel_valid;
        logic [PIXEL_BITS-1:0] pixel_out;
    } pixel_result_t;

    class stretch_scoreboard_t;
        logic [SAMPLE_BITS-1:0] lane_min [NUM_LANES];
        logic [SAMPLE_BITS-1:0] lane_max [NUM_LANES];
        pixel_result_t          expected_pixels [$];
        int                     errors;

        function new();
            for (int lane = 0; lane < NUM_LANES; lane++) begin
                lane_min[lane] = '1;
                lane_max[lane] = '0;
            end
            errors = 0;
        endfunction

        function logic [OUT_BITS-1:0] stretch_lane(logic [SAMPLE_BITS-1:0] x,
                                                   logic [SAMPLE_BITS-1:0] lo,
                                                   logic [SAMPLE_BITS-1:0] hi);
            logic [SAMPLE_BITS-1:0]          span_w;
            logic [SAMPLE_BITS-1:0]          delta;
            logic [SAMPLE_BITS+OUT_BITS-1:0] scaled;
            if (hi <= lo || x <= lo) begin
                return '0;
            end
            span_w = hi - lo;
            delta = x - lo;
            if (delta >= span_w) begin
                return PIX_MAX;
            end
            scaled = {{OUT_BITS{1'b0}}, delta} * {{SAMPLE_BITS{1'b0}}, PIX_MAX};
            scaled = scaled / {{OUT_BITS{1'b0}}, span_w};
            return scaled[OUT_BITS-1:0];
        endfunction

        function void note_beat(logic action, logic first, logic [SAMPLE_BITS-1:0] red,
                                logic [SAMPLE_BITS-1:0] green,
                                logic [SAMPLE_BITS-1:0] blue);
            logic [SAMPLE_BITS-1:0] samples [NUM_LANES];
            pixel_result_t          want;
            samples[LANE_RED] = red;
            samples[LANE_GREEN] = green;
            samples[LANE_BLUE] = blue;
            want = '0;
            if (action == ACT_STATS) begin
                for (int lane = 0; lane < NUM_LANES; lane++) begin
                    if (first) begin
                        lane_min[lane] = samples[lane];
                        lane_max[lane] = samples[lane];
                    end else begin
                        if (samples[lane] < lane_min[lane]) lane_min[lane] = samples[lane];
                        if (samples[lane] > lane_max[lane]) lane_max[lane] = samples[lane];
                    end
                end
            end else begin
                want.pixel_valid = 1'b1;
                for (int lane = 0; lane < NUM_LANES; lane++) begin
                    want.pixel_out[lane*OUT_BITS +: OUT_BITS] =
                        stretch_lane(samples[lane], lane_min[lane], lane_max[lane]);
                end
            end
            expected_pixels.push_back(want);
        endfunction

        function void check_beat(logic pixel_valid, logic [PIXEL_BITS-1:0] pixel_out);
            pixel_result_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, pixel_valid=%0b pixel_out=%06h",
                         $time, pixel_valid, pixel_out);
                return;
            end
            want = expected_pixels.pop_front();
            if (pixel_valid !== want.pixel_valid) begin
                errors++;
                $display("%0t: pixel_valid mismatch, expected %0b actual %0b",
                         $time, want.pixel_valid, pixel_valid);
            end
            if (pixel_out !== want.pixel_out) begin
                errors++;
                $display("%0t: pixel_out mismatch, expected %06h actual %06h",
                         $time, want.pixel_out, pixel_out);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_action = ACT_STATS;
    logic                   s_first = 1'b0;
    logic [SAMPLE_BITS-1:0] s_red_in = '0;
    logic [SAMPLE_BITS-1:0] s_green_in = '0;
    logic [SAMPLE_BITS-1:0] s_blue_in = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_pixel_valid;
    logic [PIXEL_BITS-1:0]  m_pixel_out;

    stretch_scoreboard_t sb = new();
    bit                  quiet = 1'b0;
    int                  beats_sent = 0;
    int                  stall_left = 0;
    int                  idle_cycles = 0;
    int                  lane_base [NUM_LANES];
    int                  lane_span [NUM_LANES];

    minmax_contrast_stretch #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_first(s_first),
        .s_red_in(s_red_in),
        .s_green_in(s_green_in),
        .s_blue_in(s_blue_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_valid(m_pixel_valid),
        .m_pixel_out(m_pixel_out)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_beat(m_pixel_valid, m_pixel_out);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_beat(logic action, logic first, logic [SAMPLE_BITS-1:0] red,
                             logic [SAMPLE_BITS-1:0] green, logic [SAMPLE_BITS-1:0] blue);
        int gap;
        s_valid <= 1'b1;
        s_action <= action;
        s_first <= first;
        s_red_in <= red;
        s_green_in <= green;
        s_blue_in <= blue;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_beat(action, first, red, green, blue);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] frame_sample(int lane, bit widen);
        int pad;
        int lo;
        int hi;
        if ($urandom_range(19) == 0) begin
            return SAMPLE_BITS'($urandom());
        end
        pad = widen ? lane_span[lane] / 8 + 2 : 0;
        lo = lane_base[lane] - pad;
        hi = lane_base[lane] + lane_span[lane] + pad;
        if (lo < 0) lo = 0;
        if (hi > SAMPLE_TOP) hi = SAMPLE_TOP;
        return SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    task automatic run_frame();
        int  kind;
        int  n_stats;
        int  n_pixels;
        kind = $urandom_range(9);
        quiet = ($urandom_range(4) == 0);
        for (int lane = 0; lane < NUM_LANES; lane++) begin
            case ($urandom_range(5))
                0: lane_span[lane] = 0;
                1: lane_span[lane] = $urandom_range(15, 1);
                2, 3: lane_span[lane] = $urandom_range(4095, 16);
                4: lane_span[lane] = $urandom_range(SAMPLE_TOP, 4096);
                default: lane_span[lane] = SAMPLE_TOP;
            endcase
            lane_base[lane] = $urandom_range(SAMPLE_TOP - lane_span[lane]);
        end
        if (kind == 0) begin
            repeat ($urandom_range(12, 4)) begin
                send_beat(1'($urandom()), 1'($urandom()), SAMPLE_BITS'($urandom()),
                          SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()));
            end
        end else begin
            n_stats = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            n_pixels = $urandom_range(24, 1);
            for (int i = 0; i < n_stats; i++) begin
                send_beat(ACT_STATS, (i == 0) && (kind != 1), frame_sample(LANE_RED, 0),
                          frame_sample(LANE_GREEN, 0), frame_sample(LANE_BLUE, 0));
            end
            for (int i = 0; i < n_pixels; i++) begin
                send_beat(ACT_STRETCH, ($urandom_range(7) == 0), frame_sample(LANE_RED, 1),
                          frame_sample(LANE_GREEN, 1), frame_sample(LANE_BLUE, 1));
            end
        end
    endtask

    initial begin
        int frames;
        frames = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Stretch beats before any statistics must come out black.
        send_beat(ACT_STRETCH, 1'b0, 16'h0000, 16'hFFFF, 16'h1234);
        send_beat(ACT_STRETCH, 1'b1, 16'hFFFF, 16'h0000, 16'h8000);
        send_beat(ACT_STATS, 1'b1, 16'h1000, 16'h8000, 16'h0000);
        send_beat(ACT_STATS, 1'b0, 16'h2000, 16'h8000, 16'hFFFF);
        send_beat(ACT_STATS, 1'b0, 16'h1800, 16'h8000, 16'h8000);
        send_beat(ACT_STRETCH, 1'b0, 16'h0800, 16'h8000, 16'h0000);
        send_beat(ACT_STRETCH, 1'b0, 16'h1000, 16'h0000, 16'hFFFF);
        send_beat(ACT_STRETCH, 1'b0, 16'h2000, 16'hFFFF, 16'h7FFF);
        send_beat(ACT_STRETCH, 1'b0, 16'h3000, 16'h8001, 16'h0001);
        send_beat(ACT_STRETCH, 1'b0, 16'h1001, 16'h8000, 16'hFFFE);
        send_beat(ACT_STRETCH, 1'b1, 16'h1555, 16'h8000, 16'h5555);
        send_beat(ACT_STATS, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_STATS, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(ACT_STRETCH, 1'b0, 16'hFFFF, 16'h0000, 16'hAAAA);
        send_beat(ACT_STRETCH, 1'b0, 16'h0001, 16'hFFFE, 16'h8000);
        send_beat(ACT_STATS, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_beat(ACT_STATS, 1'b0, 16'h0001, 16'h0001, 16'h0001);
        send_beat(ACT_STRETCH, 1'b0, 16'h0001, 16'h0000, 16'hFFFF);
        send_beat(ACT_STATS, 1'b1, 16'hAAAA, 16'h5555, 16'h00FF);
        send_beat(ACT_STRETCH, 1'b0, 16'hAAAA, 16'h5555, 16'h00FF);
        wait_drained();

        while (beats_sent < TARGET_BEATS) begin
            run_frame();
            frames++;
            if (frames % 6 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
